FILE: src/stt_pkg.sv
// Shared types, token kinds and byte classes for the source text tokenizer.
// Used by every module of the block; depends on nothing.
package stt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int MAX_TOKENS          = 5;

   // Token kinds as they appear on the result word.
   localparam logic [4:0] K_IDENT  = 5'd0;
   localparam logic [4:0] K_NUMBER = 5'd1;
   localparam logic [4:0] K_LET    = 5'd2;
   localparam logic [4:0] K_OUTPUT = 5'd3;
   localparam logic [4:0] K_LPAREN = 5'd4;
   localparam logic [4:0] K_RPAREN = 5'd5;
   localparam logic [4:0] K_LBRACK = 5'd6;
   localparam logic [4:0] K_RBRACK = 5'd7;
   localparam logic [4:0] K_COMMA  = 5'd8;
   localparam logic [4:0] K_SEMI   = 5'd9;
   localparam logic [4:0] K_EQUAL  = 5'd10;
   localparam logic [4:0] K_PLUS   = 5'd11;
   localparam logic [4:0] K_MINUS  = 5'd12;
   localparam logic [4:0] K_STAR   = 5'd13;
   localparam logic [4:0] K_SLASH  = 5'd14;
   localparam logic [4:0] K_AT     = 5'd15;
   localparam logic [4:0] K_QUOTE  = 5'd16;
   localparam logic [4:0] K_END    = 5'd17;
   localparam logic [4:0] K_ERROR  = 5'd18;

   // Characters with a role of their own.
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_O     = 8'h6F;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       has_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_offset;
      logic [15:0] token_length;
      logic [15:0] line_number;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
   } token_type;

   // All tokens caused by one input word.
   typedef struct packed {
      logic [2:0]                      count;
      token_type [MAX_TOKENS-1:0]      toks;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   // Symbol kind of a byte, or K_ERROR when it is not a symbol.
   function automatic logic [4:0] sym_kind(logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h5B:   k = K_LBRACK;
         8'h5D:   k = K_RBRACK;
         8'h2C:   k = K_COMMA;
         8'h3B:   k = K_SEMI;
         8'h3D:   k = K_EQUAL;
         8'h2B:   k = K_PLUS;
         8'h2D:   k = K_MINUS;
         8'h2A:   k = K_STAR;
         8'h2F:   k = K_SLASH;
         8'h40:   k = K_AT;
         8'h27:   k = K_QUOTE;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] let_char(logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0:    c = 8'h6C;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] out_char(logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0:    c = 8'h6F;
         3'd1:    c = 8'h75;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h70;
         3'd4:    c = 8'h75;
         3'd5:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Appends one token to a bundle.
   function automatic bundle_type add_tok(bundle_type b, logic [4:0] k, logic [15:0] o,
                                          logic [15:0] l, logic [15:0] ln);
      bundle_type r;
      r = b;
      r.toks[r.count] = '{kind: k, offset: o, length: l, line: ln};
      r.count = r.count + 3'd1;
      return r;
   endfunction

endpackage

FILE: src/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner, bundle queue and serialiser.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.

// The tokenizer takes one source byte per clock cycle while the bundle queue is
// not full and hands out tokens (kind, start offset, length, line) one word per
// cycle while results are popped. Each input word goes through the scanner and
// the tokens it causes (up to five) travel as a bundle through a two-entry queue;
// the serialiser then hands them out one token at a time. A byte that causes
// several tokens holds the serialiser until they are all out, which the queue
// absorbs unless such bytes come in a run. The first token of a byte is written
// into the queue at the edge that accepts the byte and then moves into the
// registered result word once that register is free.
module source_text_tokenizer_top #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  stt_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output stt_pkg::rsp_type rsp_data
);

   stt_pkg::q_status_type q_status;
   stt_pkg::bundle_type   push_bundle;
   stt_pkg::bundle_type   head_bundle;
   logic                  push;
   logic                  pop;

   assign req_full = q_status.full;

   stt_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .q_status    (q_status),
      .bundle_push (push),
      .bundle_data (push_bundle)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (pop),
      .head_data (head_bundle),
      .status    (q_status)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_bundle),
      .q_status  (q_status),
      .q_pop     (pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/stt_front.sv
// Front end of the tokenizer: scans one source byte per word and gathers every
// token that the byte causes into one bundle. Depends on stt_pkg.
module stt_front #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  stt_pkg::req_type     req_data,
   input  stt_pkg::q_status_type q_status,
   output logic                 bundle_push,
   output stt_pkg::bundle_type  bundle_data
);

   // Scanner modes.
   localparam logic [3:0] M_IDLE      = 4'd0;
   localparam logic [3:0] M_COMMENT   = 4'd1;
   localparam logic [3:0] M_ID        = 4'd2;
   localparam logic [3:0] M_KW_LET    = 4'd3;
   localparam logic [3:0] M_KW_OUT    = 4'd4;
   localparam logic [3:0] M_NUM       = 4'd5;
   localparam logic [3:0] M_EXP_MARK  = 4'd6;
   localparam logic [3:0] M_EXP_PLUS  = 4'd7;
   localparam logic [3:0] M_EXP_MINUS = 4'd8;
   localparam logic [3:0] M_EXP_DIG   = 4'd9;
   localparam logic [3:0] M_DOT       = 4'd10;
   localparam logic [3:0] M_ERR       = 4'd11;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

   logic [3:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] ts_ff, ts_in;
   logic [OFFSET_BITS-1:0] emo_ff, emo_in;
   logic [2:0]             kp_ff, kp_in;
   logic                   accept;

   function automatic logic [15:0] off16(logic [OFFSET_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[15:0];
   endfunction

   function automatic logic [15:0] line16(logic [LINE_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[15:0];
   endfunction

   // Length from one offset to another, zero if negative, saturating at 16 bits.
   function automatic logic [15:0] span16(logic [OFFSET_BITS-1:0] f,
                                          logic [OFFSET_BITS-1:0] t);
      logic [OFFSET_BITS-1:0] d;
      d = (t >= f) ? (t - f) : '0;
      return (32'(d) > 32'h0000_FFFF) ? 16'hFFFF : off16(d);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] x);
      return (x == OFF_MAX) ? x : x + 1'b1;
   endfunction

   assign accept = req_push && !q_status.full;

   // Scan of one word: the current mode first, then the idle pass where the
   // byte starts something new, then the closing of the source.
   always_comb begin
      logic [7:0]  c;
      logic        go_idle;
      logic [4:0]  wk;
      logic [4:0]  sk;
      logic        failed;
      stt_pkg::bundle_type b;

      c       = req_data.src_byte;
      go_idle = 1'b0;
      failed  = 1'b0;
      wk      = stt_pkg::K_IDENT;
      sk      = stt_pkg::sym_kind(c);
      b       = '0;
      mode_in = mode_ff;
      pos_in  = pos_ff;
      line_in = line_ff;
      ts_in   = ts_ff;
      emo_in  = emo_ff;
      kp_in   = kp_ff;

      if (req_data.has_byte) begin
         unique case (mode_ff)
            M_IDLE: begin
               go_idle = 1'b1;
            end
            M_COMMENT: begin
               if (c == stt_pkg::CH_LF) begin
                  mode_in = M_IDLE;
                  go_idle = 1'b1;
               end
            end
            M_ID, M_KW_LET, M_KW_OUT: begin
               if (!stt_pkg::is_word(c)) begin
                  if (mode_ff == M_KW_LET && kp_ff == 3'd3) wk = stt_pkg::K_LET;
                  if (mode_ff == M_KW_OUT && kp_ff == 3'd6) wk = stt_pkg::K_OUTPUT;
                  b = stt_pkg::add_tok(b, wk, off16(ts_ff), span16(ts_ff, pos_ff),
                                       line16(line_ff));
                  mode_in = M_IDLE;
                  go_idle = 1'b1;
               end else if (mode_ff == M_KW_LET) begin
                  if (kp_ff < 3'd3 && c == stt_pkg::let_char(kp_ff)) kp_in = kp_ff + 3'd1;
                  else mode_in = M_ID;
               end else if (mode_ff == M_KW_OUT) begin
                  if (kp_ff < 3'd6 && c == stt_pkg::out_char(kp_ff)) kp_in = kp_ff + 3'd1;
                  else mode_in = M_ID;
               end
            end
            M_NUM: begin
               if (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT) begin
                  mode_in = M_NUM;
               end else if (c == stt_pkg::CH_E_LO || c == stt_pkg::CH_E_UP) begin
                  emo_in  = pos_ff;
                  mode_in = M_EXP_MARK;
               end else begin
                  b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_ff),
                                       span16(ts_ff, pos_ff), line16(line_ff));
                  mode_in = M_IDLE;
                  go_idle = 1'b1;
               end
            end
            M_EXP_MARK, M_EXP_PLUS, M_EXP_MINUS: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in = M_EXP_DIG;
               end else if (mode_ff == M_EXP_MARK && c == stt_pkg::CH_PLUS) begin
                  mode_in = M_EXP_PLUS;
               end else if (mode_ff == M_EXP_MARK && c == stt_pkg::CH_MINUS) begin
                  mode_in = M_EXP_MINUS;
               end else if (mode_ff == M_EXP_MARK && stt_pkg::is_word(c)) begin
                  // The mark opens an identifier that goes on.
                  b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_ff),
                                       span16(ts_ff, emo_ff), line16(line_ff));
                  ts_in   = emo_ff;
                  kp_in   = 3'd0;
                  mode_in = M_ID;
               end else begin
                  // Unfinished exponent: number, mark and any sign come out apart.
                  b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_ff),
                                       span16(ts_ff, emo_ff), line16(line_ff));
                  b = stt_pkg::add_tok(b, stt_pkg::K_IDENT, off16(emo_ff), 16'd1,
                                       line16(line_ff));
                  if (mode_ff != M_EXP_MARK)
                     b = stt_pkg::add_tok(b, (mode_ff == M_EXP_PLUS) ? stt_pkg::K_PLUS
                                          : stt_pkg::K_MINUS, off16(sat_inc(emo_ff)),
                                          16'd1, line16(line_ff));
                  mode_in = M_IDLE;
                  go_idle = 1'b1;
               end
            end
            M_EXP_DIG: begin
               if (!stt_pkg::is_digit(c)) begin
                  b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_ff),
                                       span16(ts_ff, pos_ff), line16(line_ff));
                  mode_in = M_IDLE;
                  go_idle = 1'b1;
               end
            end
            M_DOT: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in = M_NUM;
               end else begin
                  b = stt_pkg::add_tok(b, stt_pkg::K_ERROR, off16(ts_ff), 16'd1,
                                       line16(line_ff));
                  mode_in = M_ERR;
               end
            end
            default: begin
               mode_in = M_ERR;
            end
         endcase

         // Idle pass: the byte starts something new.
         if (go_idle) begin
            if (c == stt_pkg::CH_LF) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
            end else if (stt_pkg::is_space(c)) begin
               mode_in = M_IDLE;
            end else if (c == stt_pkg::CH_HASH) begin
               mode_in = M_COMMENT;
            end else if (stt_pkg::is_alpha(c) || c == stt_pkg::CH_UNDER) begin
               ts_in   = pos_ff;
               kp_in   = 3'd1;
               mode_in = (c == stt_pkg::CH_L) ? M_KW_LET
                         : ((c == stt_pkg::CH_O) ? M_KW_OUT : M_ID);
            end else if (stt_pkg::is_digit(c)) begin
               ts_in   = pos_ff;
               mode_in = M_NUM;
            end else if (c == stt_pkg::CH_DOT) begin
               ts_in   = pos_ff;
               mode_in = M_DOT;
            end else if (sk != stt_pkg::K_ERROR) begin
               b = stt_pkg::add_tok(b, sk, off16(pos_ff), 16'd1, line16(line_ff));
            end else begin
               b = stt_pkg::add_tok(b, stt_pkg::K_ERROR, off16(pos_ff), 16'd1,
                                    line16(line_ff));
               mode_in = M_ERR;
            end
         end
         pos_in = sat_inc(pos_ff);
      end

      // Closing of the source: flush the pending token, then the end token unless the scan failed.
      if (req_data.end_of_source) begin
         wk = stt_pkg::K_IDENT;
         if (mode_in == M_KW_LET && kp_in == 3'd3) wk = stt_pkg::K_LET;
         if (mode_in == M_KW_OUT && kp_in == 3'd6) wk = stt_pkg::K_OUTPUT;
         case (mode_in)
            M_ID, M_KW_LET, M_KW_OUT: begin
               b = stt_pkg::add_tok(b, wk, off16(ts_in), span16(ts_in, pos_in),
                                    line16(line_in));
            end
            M_NUM, M_EXP_DIG: begin
               b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_in),
                                    span16(ts_in, pos_in), line16(line_in));
            end
            M_EXP_MARK, M_EXP_PLUS, M_EXP_MINUS: begin
               b = stt_pkg::add_tok(b, stt_pkg::K_NUMBER, off16(ts_in),
                                    span16(ts_in, emo_in), line16(line_in));
               b = stt_pkg::add_tok(b, stt_pkg::K_IDENT, off16(emo_in), 16'd1,
                                    line16(line_in));
               if (mode_in != M_EXP_MARK)
                  b = stt_pkg::add_tok(b, (mode_in == M_EXP_PLUS) ? stt_pkg::K_PLUS
                                       : stt_pkg::K_MINUS, off16(sat_inc(emo_in)),
                                       16'd1, line16(line_in));
            end
            M_DOT: begin
               b = stt_pkg::add_tok(b, stt_pkg::K_ERROR, off16(ts_in), 16'd1,
                                    line16(line_in));
               failed = 1'b1;
            end
            M_ERR: begin
               failed = 1'b1;
            end
            default: begin
               failed = 1'b0;
            end
         endcase
         if (!failed)
            b = stt_pkg::add_tok(b, stt_pkg::K_END, off16(pos_in), 16'd0, line16(line_in));
         mode_in = M_IDLE;
         pos_in  = '0;
         line_in = LINE_BITS'(1);
         ts_in   = '0;
         emo_in  = '0;
         kp_in   = 3'd0;
      end

      bundle_data = b;
   end

   assign bundle_push = accept && (bundle_data.count != 3'd0);

   // Scanner state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pos_ff  <= '0;
         line_ff <= LINE_BITS'(1);
         ts_ff   <= '0;
         emo_ff  <= '0;
         kp_ff   <= 3'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
         ts_ff   <= ts_in;
         emo_ff  <= emo_in;
         kp_ff   <= kp_in;
      end
   end

endmodule

FILE: src/stt_queue.sv
// Two-entry queue of token bundles between the scanner and the serialiser.
// Depends on stt_pkg.
module stt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stt_pkg::bundle_type   push_data,
   input  logic                  pop,
   output stt_pkg::bundle_type   head_data,
   output stt_pkg::q_status_type status
);

   stt_pkg::bundle_type mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_data    = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

   // Pointer and fill level update.
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("bundle pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("bundle popped from an empty queue");
   a_level: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue level out of range");
   a_bundle_size: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.count != 3'd0) && (push_data.count <= 3'd5))
      else $error("bundle with a bad token count");

endmodule

FILE: src/stt_back.sv
// Back end of the tokenizer: walks the head bundle one token a cycle into the
// registered result word whenever that register is free. Depends on stt_pkg.
module stt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::bundle_type   head_data,
   input  stt_pkg::q_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output stt_pkg::rsp_type      rsp_data
);

   logic             valid_ff, valid_in;
   logic [2:0]       idx_ff, idx_in;
   stt_pkg::rsp_type rsp_ff, rsp_in;
   stt_pkg::token_type tok;
   logic             load;
   logic             last;

   assign tok  = head_data.toks[idx_ff];
   assign last = (idx_ff == head_data.count - 3'd1);
   assign load = !valid_ff || rsp_pop;

   // Next token into the result register whenever it is free.
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            rsp_in = '{token_kind: tok.kind, token_offset: tok.offset,
                       token_length: tok.length, line_number: tok.line,
                       last_result: last};
            if (last) begin
               q_pop  = 1'b1;
               idx_in = 3'd0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
